// ----- design/spu_enc_pkg.sv -----
// Package for the sound-unit ADPCM block encoder.
// Holds shared constants, the configuration types, the job descriptor, the store write port and the back-end states.
// No dependencies.
package spu_enc_pkg;

  // Block geometry and limits
  localparam int unsigned BLOCK_SAMPLES = 28;
  localparam int unsigned MAX_SAMPLES   = 64000;
  localparam int unsigned FILL_W        = 5;
  localparam int unsigned MEM_AW        = FILL_W + 1;
  localparam int unsigned MEM_DEPTH     = 1 << MEM_AW;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned QPTR_W        = 1;
  localparam int unsigned QCNT_W        = 2;
  localparam int unsigned NIB_W         = 4 * BLOCK_SAMPLES;

  // Header codes
  localparam logic [15:0] HDR_FILTER1    = 16'h0010;
  localparam logic [15:0] HDR_LOOP_START = 16'h0400;
  localparam logic [15:0] HDR_LOOP_END   = 16'h0300;
  localparam logic [15:0] HDR_SILENCE    = 16'h0500;
  localparam logic [3:0]  MAX_SHIFT      = 4'd12;

  // Sample and loop constants
  localparam logic [7:0]  ZERO_LEVEL  = 8'h80;
  localparam int unsigned LOOP_WINDOW = 14;
  localparam int unsigned LOOP_OFF    = 64;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_SAMPLE_LENGTH = 3'd0,
    CFG_LOOP_ENABLED  = 3'd1,
    CFG_LOOP_BEGIN    = 3'd2,
    CFG_LOOP_END      = 3'd3,
    CFG_BASE_BLOCK    = 3'd4
  } cfg_idx_e;

  // Configuration seen by the front end
  typedef struct packed {
    logic [15:0] sample_length;
    logic        loop_enabled;
    logic [15:0] loop_begin;
    logic [15:0] loop_end;
  } cfg_t;

  // Write port into the sample store
  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
    logic [7:0]        data;
  } wr_t;

  // One block to encode; lo and hi are the signed sample extremes (zero-level removed)
  typedef struct packed {
    logic              bank;
    logic [FILL_W-1:0] fill;
    logic [7:0]        lo;
    logic [7:0]        hi;
    logic              loop_start;
    logic              loop_end;
    logic              silence;
  } job_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    B_IDLE,
    B_RANGE,
    B_SHIFT,
    B_QUANT,
    B_DRAIN,
    B_EMIT
  } back_state_e;

endpackage

// ----- design/spu_enc_front.sv -----
// Front end of the ADPCM block encoder: takes sample beats, fills the store and classifies blocks.
// Pushes one job per finished block, with extremes and loop flags. Depends on spu_enc_pkg.
module spu_enc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          sample_byte_i,
  input  spu_enc_pkg::cfg_t   cfg_i,
  input  logic                queue_full_i,
  output logic                job_push_o,
  output spu_enc_pkg::job_t   job_o,
  output spu_enc_pkg::wr_t    wr_o
);
  import spu_enc_pkg::*;

  logic [FILL_W-1:0] fill_q, fill_d;
  logic [15:0]       pos_q, pos_d;
  logic              bank_q, bank_d;
  logic [7:0]        lo_q, lo_d, hi_q, hi_d;

  logic              accept, last, capture, blk_done, silence;
  logic [16:0]       pos_inc;
  logic [FILL_W-1:0] fill_inc;
  logic [7:0]        t_in, cur_lo, cur_hi, pad_lo, pad_hi;
  logic [15:0]       start;
  logic signed [18:0] len_s, lpb_s, lpe_raw_s, lpe_lim_s, lpe_s, start_s, win_hi_s, win_lo_s;
  logic              flag_start, flag_end;

  // A bank is free whenever the queue has room, so the beat can go straight in.
  assign accept     = in_valid_i && !queue_full_i;
  assign in_ready_o = !queue_full_i;

  // Position tracking and block boundaries
  always_comb begin
    pos_inc  = {1'b0, pos_q} + 17'd1;
    last     = pos_inc >= {1'b0, cfg_i.sample_length};
    capture  = (fill_q != '0) || (pos_q < 16'(MAX_SAMPLES));
    fill_inc = fill_q + FILL_W'(1);
    blk_done = (fill_inc == FILL_W'(BLOCK_SAMPLES)) || last;
    silence  = last || (pos_inc >= 17'(MAX_SAMPLES));
    start    = pos_q + 16'd1 - {{(16 - FILL_W){1'b0}}, fill_inc};
  end

  // Running extremes of the signed samples; a padded block also holds zero level.
  always_comb begin
    t_in   = sample_byte_i ^ ZERO_LEVEL;
    cur_lo = ((fill_q == '0) || ($signed(t_in) < $signed(lo_q))) ? t_in : lo_q;
    cur_hi = ((fill_q == '0) || ($signed(t_in) > $signed(hi_q))) ? t_in : hi_q;
    pad_lo = cur_lo;
    pad_hi = cur_hi;
    if (fill_inc != FILL_W'(BLOCK_SAMPLES)) begin
      if ($signed(cur_lo) > 8'sd0) pad_lo = '0;
      if ($signed(cur_hi) < 8'sd0) pad_hi = '0;
    end
  end

  // Loop point windows around the block start
  always_comb begin
    len_s     = $signed({3'b000, cfg_i.sample_length});
    lpe_raw_s = $signed({3'b000, cfg_i.loop_end}) + 19'sd1;
    lpe_lim_s = len_s - 19'(LOOP_WINDOW);
    if (cfg_i.loop_enabled) begin
      lpb_s = $signed({3'b000, cfg_i.loop_begin});
      lpe_s = (lpe_raw_s > lpe_lim_s) ? lpe_lim_s : lpe_raw_s;
    end else begin
      lpb_s = len_s + 19'(LOOP_OFF);
      lpe_s = len_s + 19'(LOOP_OFF);
    end
    start_s    = $signed({3'b000, start});
    win_hi_s   = start_s + 19'(LOOP_WINDOW);
    win_lo_s   = start_s - 19'(LOOP_WINDOW);
    flag_start = (lpb_s <= win_hi_s) && (lpb_s > win_lo_s);
    flag_end   = (lpe_s <= win_hi_s) && (lpe_s > win_lo_s);
  end

  // Job and store write
  always_comb begin
    job_push_o       = accept && capture && blk_done;
    job_o.bank       = bank_q;
    job_o.fill       = fill_inc;
    job_o.lo         = pad_lo;
    job_o.hi         = pad_hi;
    job_o.loop_start = flag_start;
    job_o.loop_end   = flag_end;
    job_o.silence    = silence;
    wr_o.en          = accept && capture;
    wr_o.addr        = {bank_q, fill_q};
    wr_o.data        = sample_byte_i;
  end

  // Next state of the fill logic
  always_comb begin
    fill_d = fill_q;
    pos_d  = pos_q;
    bank_d = bank_q;
    lo_d   = lo_q;
    hi_d   = hi_q;
    if (accept) begin
      if (capture) begin
        if (blk_done) begin
          fill_d = '0;
          bank_d = !bank_q;
        end else begin
          fill_d = fill_inc;
          lo_d   = cur_lo;
          hi_d   = cur_hi;
        end
      end
      if (last) begin
        pos_d  = '0;
        fill_d = '0;
      end else begin
        pos_d = pos_inc[15:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      pos_q  <= '0;
      bank_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      pos_q  <= pos_d;
      bank_q <= bank_d;
    end
  end

  // Extremes are payload
  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
  end

endmodule

// ----- design/spu_enc_queue.sv -----
// Two-entry job queue between the front and back ends of the ADPCM encoder.
// The head stays in place until the back end has delivered the block. Depends on spu_enc_pkg.
module spu_enc_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  spu_enc_pkg::job_t job_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              valid_o,
  output spu_enc_pkg::job_t job_o
);
  import spu_enc_pkg::*;

  job_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == QCNT_W'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign job_o   = entry_q[rptr_q];

  // Pointer and count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) wptr_d = wptr_q + QPTR_W'(1);
    if (pop_i)  rptr_d = rptr_q + QPTR_W'(1);
    if (push_i && !pop_i) cnt_d = cnt_q + QCNT_W'(1);
    if (pop_i && !push_i) cnt_d = cnt_q - QCNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wptr_q] <= job_i;
  end

endmodule

// ----- design/spu_enc_back.sv -----
// Back end of the ADPCM block encoder: picks the shift, runs the serial quantizer and delivers blocks.
// Owns the double-banked sample store, the predictor and the block pointer. Depends on spu_enc_pkg.
module spu_enc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  spu_enc_pkg::wr_t  wr_i,
  input  logic              job_valid_i,
  input  spu_enc_pkg::job_t job_i,
  output logic              pop_o,
  input  logic              base_load_i,
  input  logic [15:0]       base_block_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [15:0]       header_word_o,
  output logic [spu_enc_pkg::NIB_W-1:0] nibbles_o,
  output logic [15:0]       block_address_o,
  output logic              loop_start_here_o,
  output logic              run_last_o
);
  import spu_enc_pkg::*;

  back_state_e       state_q, state_d;
  logic [FILL_W-1:0] k_q, k_d;
  logic [17:0]       pred_q, pred_d;
  logic [18:0]       range_q, range_d;
  logic [3:0]        shift_q, shift_d;
  logic [NIB_W-1:0]  nib_q;
  logic [15:0]       bp_q, bp_d;
  logic              sil_q, sil_d;
  logic              rv_q;
  logic [FILL_W-1:0] rk_q;
  logic [7:0]        rd_q;
  logic [7:0]        mem [MEM_DEPTH];

  logic              issue, out_acc, job_end;
  logic [17:0]       lo_v, hi_v, mn, mx;
  logic [4:0]        blen;
  logic [7:0]        byte_s;
  logic [17:0]       v18, dsh;
  logic signed [19:0] diff, rnd, sum, q;
  logic [3:0]        d4;
  logic [15:0]       hdr;

  assign out_acc = out_valid_o && out_ready_i;
  assign job_end = out_acc && (sil_q || !job_i.silence);

  // Sample store: written by the front end, read one entry per quantizer step
  always_ff @(posedge clk_i) begin
    if (wr_i.en) mem[wr_i.addr] <= wr_i.data;
    if (issue) rd_q <= mem[{job_i.bank, k_q}];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE:  if (job_valid_i) state_d = B_RANGE;
      B_RANGE: state_d = B_SHIFT;
      B_SHIFT: state_d = B_QUANT;
      B_QUANT: if (k_q == FILL_W'(BLOCK_SAMPLES - 1)) state_d = B_DRAIN;
      B_DRAIN: state_d = B_EMIT;
      B_EMIT:  if (job_end) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    issue       = state_q == B_QUANT;
    out_valid_o = state_q == B_EMIT;
    pop_o       = (state_q == B_EMIT) && job_end;
  end

  // Range of the block together with the predictor
  always_comb begin
    lo_v    = {{2{job_i.lo[7]}}, job_i.lo, 8'h00};
    hi_v    = {{2{job_i.hi[7]}}, job_i.hi, 8'h00};
    mn      = ($signed(pred_q) < $signed(lo_v)) ? pred_q : lo_v;
    mx      = ($signed(pred_q) > $signed(hi_v)) ? pred_q : hi_v;
    range_d = {mx[17], mx} - {mn[17], mn};
  end

  // Shift: bit length of the range minus four, at most twelve
  always_comb begin
    blen = '0;
    for (int i = 0; i < 19; i++) begin
      if (range_q[i]) blen = 5'(i + 1);
    end
    if (blen <= 5'd4)                blen = 5'd4;
    if (blen - 5'd4 > {1'b0, MAX_SHIFT}) shift_d = MAX_SHIFT;
    else                             shift_d = 4'(blen - 5'd4);
  end

  // One quantizer step: rounded, shifted, clamped delta; predictor follows it
  always_comb begin
    byte_s = rd_q ^ ZERO_LEVEL;
    v18    = (rk_q < job_i.fill) ? {{2{byte_s[7]}}, byte_s, 8'h00} : '0;
    diff   = $signed({{2{v18[17]}}, v18}) - $signed({{2{pred_q[17]}}, pred_q});
    rnd    = (shift_q == '0) ? '0 : $signed(20'd1 << (shift_q - 4'd1));
    sum    = diff + rnd;
    q      = sum >>> shift_q;
    if (q < -20'sd8)     d4 = 4'h8;
    else if (q > 20'sd7) d4 = 4'h7;
    else                 d4 = q[3:0];
    dsh    = {{14{d4[3]}}, d4} << shift_q;
    pred_d = pred_q;
    if (rv_q) pred_d = pred_q + dsh;
  end

  // Counters, silence phase and block pointer
  always_comb begin
    k_d   = k_q;
    sil_d = sil_q;
    bp_d  = bp_q;
    if (state_q == B_SHIFT) k_d = '0;
    if (issue)              k_d = k_q + FILL_W'(1);
    if (out_acc) begin
      bp_d  = bp_q + 16'd2;
      sil_d = !job_end;
    end
    if (base_load_i) bp_d = base_block_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      k_q     <= '0;
      pred_q  <= '0;
      sil_q   <= 1'b0;
      bp_q    <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      pred_q  <= pred_d;
      sil_q   <= sil_d;
      bp_q    <= bp_d;
      rv_q    <= issue;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    rk_q <= k_q;
    if (state_q == B_RANGE) range_q <= range_d;
    if (state_q == B_SHIFT) shift_q <= shift_d;
    if (rv_q) nib_q <= {d4, nib_q[NIB_W-1:4]};
  end

  // Result fields
  always_comb begin
    hdr = HDR_FILTER1 | {12'h000, MAX_SHIFT - shift_q};
    if (job_i.loop_start) hdr = hdr | HDR_LOOP_START;
    if (job_i.loop_end)   hdr = hdr | HDR_LOOP_END;
    header_word_o     = sil_q ? HDR_SILENCE : hdr;
    nibbles_o         = sil_q ? '0 : nib_q;
    block_address_o   = bp_q;
    loop_start_here_o = !sil_q && job_i.loop_start;
    run_last_o        = sil_q || !job_i.silence;
  end

endmodule

// ----- design/spu_adpcm_block_encoder.sv -----
// Top level of the ADPCM block encoder: configuration registers and the front/queue/back chain.
// A closed block passes the queue and the range, shift, quantize and drain states before its result beat.
// Throughput: one sample beat per cycle while a store bank is free; the back end's 28-step
// quantizer loop is followed by one or two result beats per block.
// Reset: asynchronous, active low; registers take their defaults, predictor and pointer go to zero.
module spu_adpcm_block_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  sample_byte_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] header_word_o,
  output logic [15:0] data_word_1_o,
  output logic [15:0] data_word_2_o,
  output logic [15:0] data_word_3_o,
  output logic [15:0] data_word_4_o,
  output logic [15:0] data_word_5_o,
  output logic [15:0] data_word_6_o,
  output logic [15:0] data_word_7_o,
  output logic [15:0] block_address_o,
  output logic        loop_start_here_o,
  output logic        run_last_o
);
  import spu_enc_pkg::*;

  cfg_t             cfg_q, cfg_d;
  logic             base_load;
  logic             queue_full, job_push, job_valid, job_pop;
  job_t             job_in, job_head;
  wr_t              wr;
  logic [NIB_W-1:0] nibbles;

  // Configuration register writes
  always_comb begin
    cfg_d     = cfg_q;
    base_load = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_SAMPLE_LENGTH: cfg_d.sample_length = cfg_data_i;
        CFG_LOOP_ENABLED:  cfg_d.loop_enabled  = cfg_data_i[0];
        CFG_LOOP_BEGIN:    cfg_d.loop_begin    = cfg_data_i;
        CFG_LOOP_END:      cfg_d.loop_end      = cfg_data_i;
        CFG_BASE_BLOCK:    base_load           = 1'b1;
        default:           cfg_d               = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_length <= 16'd1;
      cfg_q.loop_enabled  <= 1'b0;
      cfg_q.loop_begin    <= '0;
      cfg_q.loop_end      <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  spu_enc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sample_byte_i (sample_byte_i),
    .cfg_i         (cfg_q),
    .queue_full_i  (queue_full),
    .job_push_o    (job_push),
    .job_o         (job_in),
    .wr_o          (wr)
  );

  spu_enc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job_in),
    .pop_i   (job_pop),
    .full_o  (queue_full),
    .valid_o (job_valid),
    .job_o   (job_head)
  );

  spu_enc_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .wr_i              (wr),
    .job_valid_i       (job_valid),
    .job_i             (job_head),
    .pop_o             (job_pop),
    .base_load_i       (base_load),
    .base_block_i      (cfg_data_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .header_word_o     (header_word_o),
    .nibbles_o         (nibbles),
    .block_address_o   (block_address_o),
    .loop_start_here_o (loop_start_here_o),
    .run_last_o        (run_last_o)
  );

  // Data words, four nibbles each, lowest sample first
  assign data_word_1_o = nibbles[15:0];
  assign data_word_2_o = nibbles[31:16];
  assign data_word_3_o = nibbles[47:32];
  assign data_word_4_o = nibbles[63:48];
  assign data_word_5_o = nibbles[79:64];
  assign data_word_6_o = nibbles[95:80];
  assign data_word_7_o = nibbles[111:96];

endmodule
